// File: rtl/sle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_pkg: shared types of the sorted list engine
// Command and status codes, and the token that walks the cell chain.
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_OUT_W = 5;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_SEARCH = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_POP    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // One command travelling down the chain, one cell per cycle.
    // flag: insert = still carrying a value, search = hit seen,
    //       delete/pop = shifting left from here on.
    typedef struct packed {
        logic                      vld;
        t_mode                     mode;
        logic                      nop;
        logic                      flag;
        logic signed [VALUE_W-1:0] carry;
    } t_token;

    typedef struct packed {
        t_status                   status;
        logic signed [VALUE_W-1:0] popped;
        logic [COUNT_OUT_W-1:0]    count;
    } t_result;

endpackage

// File: rtl/sle_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_cell: one slot of the sorted list
// Holds one entry, applies the passing command to it and forwards the token.
// ----------------------------------------------------------------------------
module sle_cell
    import sle_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_token                    i_tok,
    input  logic [CW-1:0]             i_count,
    input  logic signed [VALUE_W-1:0] i_next_value,
    output t_token                    o_tok,
    output logic signed [VALUE_W-1:0] o_value
);

    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;
    t_token                    r_tok;
    t_token                    n_tok;
    logic                      live;

    assign live = CW'(IDX) < i_count;

    always_comb begin
        n_value = r_value;
        n_tok   = i_tok;
        if (i_tok.vld && !i_tok.nop) begin
            case (i_tok.mode)
                MODE_INSERT: begin
                    // swap the carried value in; the old entry moves on
                    if (i_tok.flag && (!live || (i_tok.carry < r_value))) begin
                        n_value     = i_tok.carry;
                        n_tok.carry = r_value;
                        n_tok.flag  = live;
                    end
                end
                MODE_SEARCH: begin
                    if (live && (r_value == i_tok.carry)) begin
                        n_tok.flag = 1'b1;
                    end
                end
                MODE_DELETE: begin
                    if (i_tok.flag || (live && (r_value == i_tok.carry))) begin
                        n_value    = i_next_value;
                        n_tok.flag = 1'b1;
                    end
                end
                MODE_POP: begin
                    if (i_tok.flag) begin
                        n_value = i_next_value;
                        if (IDX == 0) begin
                            n_tok.carry = r_value;
                        end
                    end
                end
                default: begin
                    n_value = r_value;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok   = r_tok;
    assign o_value = r_value;

endmodule

// File: rtl/sorted_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_engine: bounded sorted multiset with insert/search/delete/pop
// Ascending list of signed 32-bit values kept in a chain of cells.
// ----------------------------------------------------------------------------
// Each command is registered, then walks the chain of CAPACITY cells one cell
// per cycle, each cell updating its own entry as the token passes; the result
// then lands in the output register. One command is in the chain at a time.
// A new command is taken as soon as the previous result has reached the
// output register, even if that result has not yet been taken. No clearing
// pass is needed after reset.
module sorted_list_engine
    import sle_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_mode,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [1:0]                o_status,
    output logic signed [VALUE_W-1:0] o_popped_value,
    output logic [COUNT_OUT_W-1:0]    o_entry_count
);

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_WAIT = 3'b100
    } t_state;

    t_state                    r_state, n_state;
    logic [CW-1:0]             r_count, n_count;
    t_token                    r_tok0, n_tok0;
    t_result                   r_pend, n_pend;
    t_result                   r_out, n_out;
    logic                      r_out_valid, n_out_valid;
    t_result                   fin;
    t_token                    tok [0:CAPACITY];
    logic signed [VALUE_W-1:0] val [0:CAPACITY-1];
    logic                      accept;
    logic                      out_free;
    t_mode                     in_mode;

    assign tok[0] = r_tok0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [VALUE_W-1:0] next_value;
        if (g == CAPACITY - 1) begin : g_last
            assign next_value = val[g];
        end else begin : g_mid
            assign next_value = val[g+1];
        end
        sle_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_tok        (tok[g]),
            .i_count      (r_count),
            .i_next_value (next_value),
            .o_tok        (tok[g+1]),
            .o_value      (val[g])
        );
    end

    assign in_mode  = t_mode'(i_mode);
    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // Result and new count from the token leaving the last cell.
    always_comb begin
        n_count    = r_count;
        fin.status = ST_DONE;
        fin.popped = '0;
        case (tok[CAPACITY].mode)
            MODE_INSERT: begin
                if (tok[CAPACITY].nop) begin
                    fin.status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            MODE_SEARCH: begin
                fin.status = tok[CAPACITY].flag ? ST_DONE : ST_NOT_FOUND;
            end
            MODE_DELETE: begin
                if (tok[CAPACITY].flag) begin
                    n_count = r_count - CW'(1);
                end else begin
                    fin.status = ST_NOT_FOUND;
                end
            end
            MODE_POP: begin
                if (tok[CAPACITY].nop) begin
                    fin.status = ST_EMPTY;
                end else begin
                    fin.popped = tok[CAPACITY].carry;
                    n_count    = r_count - CW'(1);
                end
            end
            default: begin
                fin.status = ST_DONE;
            end
        endcase
        if (!tok[CAPACITY].vld) begin
            n_count = r_count;
        end
        fin.count = COUNT_OUT_W'(n_count);
    end

    always_comb begin
        n_state     = r_state;
        n_tok0      = r_tok0;
        n_tok0.vld  = 1'b0;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_tok0.vld   = 1'b1;
                    n_tok0.mode  = in_mode;
                    n_tok0.carry = i_value;
                    n_tok0.nop   = ((in_mode == MODE_INSERT) && (r_count == CW'(CAPACITY)))
                                || ((in_mode == MODE_POP) && (r_count == '0));
                    n_tok0.flag  = (in_mode == MODE_INSERT) || (in_mode == MODE_POP);
                    n_state      = S_RUN;
                end
            end
            S_RUN: begin
                if (tok[CAPACITY].vld) begin
                    if (out_free) begin
                        n_out       = fin;
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        // hold the result until the output register drains
                        n_pend  = fin;
                        n_state = S_WAIT;
                    end
                end
            end
            S_WAIT: begin
                if (out_free) begin
                    n_out       = r_pend;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_out  <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_tok0      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_tok0      <= n_tok0;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_popped_value = r_out.popped;
    assign o_entry_count  = r_out.count;

endmodule

// File: dv/sorted_list_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_engine_test: self-checking bench for the sorted list engine
// Drives insert, search, delete and pop commands through the valid/ready
// input and checks every result against a behavioral copy of the sorted store.
// Directed corner commands come first. Random traffic then alternates between
// filling and draining the store under three idling mixes, with long receiver
// stalls at the start of the first and last phases and sender pauses between phases.
// ----------------------------------------------------------------------------
module sorted_list_engine_test;
    import sle_pkg::*;

    localparam int DEPTH       = 16;
    localparam int LATENCY     = DEPTH + 4;
    localparam int STALL_LIMIT = 3000;
    localparam int PHASE_ITEMS = 580;

    localparam logic signed [VALUE_W-1:0] VMAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VMIN = 32'sh8000_0000;

    // Sorted store as the block should hold it, plus the results it owes.
    class list_scoreboard;
        logic signed [VALUE_W-1:0] slots [DEPTH];
        int                        used;
        t_result                   pending [$];
        int unsigned               errors;
        int unsigned               commands;
        int unsigned               results_seen;
        int unsigned               status_seen [4];

        function new();
            used         = 0;
            errors       = 0;
            commands     = 0;
            results_seen = 0;
            foreach (status_seen[k]) status_seen[k] = 0;
        endfunction

        function int first_not_below(logic signed [VALUE_W-1:0] v);
            int p;
            p = 0;
            while (p < used && slots[p] < v) p++;
            return p;
        endfunction

        function void note_command(t_mode m, logic signed [VALUE_W-1:0] v);
            t_result r;
            int      p;
            r.status = ST_DONE;
            r.popped = '0;
            commands++;
            case (m)
                MODE_INSERT: begin
                    if (used >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        // equal values: new entry lands in front of them
                        p = first_not_below(v);
                        for (int i = used; i > p; i--) slots[i] = slots[i-1];
                        slots[p] = v;
                        used++;
                    end
                end
                MODE_SEARCH: begin
                    p = first_not_below(v);
                    if (!(p < used && slots[p] == v)) r.status = ST_NOT_FOUND;
                end
                MODE_DELETE: begin
                    p = first_not_below(v);
                    if (p < used && slots[p] == v) begin
                        for (int i = p; i < used - 1; i++) slots[i] = slots[i+1];
                        used--;
                    end else begin
                        r.status = ST_NOT_FOUND;
                    end
                end
                default: begin
                    if (used == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.popped = slots[0];
                        for (int i = 0; i < used - 1; i++) slots[i] = slots[i+1];
                        used--;
                    end
                end
            endcase
            r.count = COUNT_OUT_W'(used);
            pending.push_back(r);
        endfunction

        function void check_result(logic [1:0] s, logic signed [VALUE_W-1:0] pv,
                                   logic [COUNT_OUT_W-1:0] c);
            t_result want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected beat: status %0d popped %0d count %0d",
                         $time, s, pv, c);
                errors++;
                return;
            end
            want = pending.pop_front();
            results_seen++;
            status_seen[want.status]++;
            if (s !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, s);
                errors++;
            end
            if (pv !== want.popped) begin
                $display("%0t: popped_value expected %0d actual %0d",
                         $time, want.popped, pv);
                errors++;
            end
            if (c !== want.count) begin
                $display("%0t: entry_count expected %0d actual %0d", $time, want.count, c);
                errors++;
            end
        endfunction
    endclass

    logic                      i_clk;
    logic                      rst_n;
    logic                      cmd_valid;
    t_mode                     cmd_mode;
    logic signed [VALUE_W-1:0] cmd_value;
    logic                      rsp_ready;
    logic                      o_in_ready;
    logic                      o_out_valid;
    logic [1:0]                o_status;
    logic signed [VALUE_W-1:0] o_popped_value;
    logic [COUNT_OUT_W-1:0]    o_entry_count;

    list_scoreboard sb;
    int             tx_idle_pct;
    int             rx_idle_pct;
    int             hold_off;
    int             stall_cycles;

    sorted_list_engine #(
        .CAPACITY(DEPTH)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (cmd_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (cmd_mode),
        .i_value        (cmd_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (rsp_ready),
        .o_status       (o_status),
        .o_popped_value (o_popped_value),
        .o_entry_count  (o_entry_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: random back-pressure, or a long hold when one is requested.
    initial begin
        rsp_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off > 0) begin
                rsp_ready <= 1'b0;
                hold_off--;
            end else begin
                rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Record each beat on both sides and watch for a hang.
    always @(posedge i_clk) begin
        if (rst_n) begin
            if (cmd_valid && o_in_ready) sb.note_command(cmd_mode, cmd_value);
            if (o_out_valid && rsp_ready)
                sb.check_result(o_status, o_popped_value, o_entry_count);
            if ((cmd_valid && o_in_ready) || (o_out_valid && rsp_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Valid stays up after a beat; the next command or a gap decides what follows.
    task automatic send_command(input t_mode m, input logic signed [VALUE_W-1:0] v);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            cmd_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        cmd_valid <= 1'b1;
        cmd_mode  <= m;
        cmd_value <= v;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drop valid, then hold until every owed result has been taken.
    task automatic drain_results();
        cmd_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int unsigned               r;
        logic signed [VALUE_W-1:0] v;
        r = $urandom_range(99);
        if (r < 40 && sb.used != 0) begin
            v = sb.slots[$urandom_range(sb.used - 1)];
        end else if (r < 50) begin
            case ($urandom_range(4))
                0:       v = VMAX;
                1:       v = VMIN;
                2:       v = -32'sd1;
                3:       v = VMIN + 32'sd1;
                default: v = '0;
            endcase
        end else if (r < 70) begin
            v = $signed($urandom_range(15)) - 32'sd8;
        end else begin
            v = $urandom;
        end
        return v;
    endfunction

    function automatic t_mode pick_mode(input int insert_pct);
        t_mode m;
        if ($urandom_range(99) < insert_pct) begin
            m = MODE_INSERT;
        end else begin
            case ($urandom_range(2))
                0:       m = MODE_SEARCH;
                1:       m = MODE_DELETE;
                default: m = MODE_POP;
            endcase
        end
        return m;
    endfunction

    // Alternate fill-heavy and drain-heavy stretches so full and empty both recur.
    task automatic random_run(input int items);
        int insert_pct;
        insert_pct = 70;
        for (int n = 0; n < items; n++) begin
            if (n % 48 == 0) insert_pct = ((n / 48) % 2 == 0) ? 70 : 10;
            send_command(pick_mode(insert_pct), pick_value());
        end
    endtask

    initial begin
        sb           = new();
        rst_n        = 1'b0;
        cmd_valid    = 1'b0;
        cmd_mode     = MODE_INSERT;
        cmd_value    = '0;
        tx_idle_pct  = 24;
        rx_idle_pct  = 63;
        hold_off     = 0;
        stall_cycles = 0;
        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;

        // empty store, extremes, duplicates, first-entry delete
        send_command(MODE_POP,    '0);
        send_command(MODE_SEARCH, 32'sd5);
        send_command(MODE_DELETE, 32'sd5);
        send_command(MODE_INSERT, VMAX);
        send_command(MODE_INSERT, VMIN);
        send_command(MODE_INSERT, '0);
        send_command(MODE_INSERT, '0);
        send_command(MODE_INSERT, -32'sd1);
        send_command(MODE_INSERT, 32'sd1);
        send_command(MODE_SEARCH, '0);
        send_command(MODE_SEARCH, 32'sd2);
        send_command(MODE_SEARCH, VMAX);
        send_command(MODE_SEARCH, VMIN);
        send_command(MODE_DELETE, VMIN);
        send_command(MODE_DELETE, 32'sd3);
        send_command(MODE_DELETE, '0);
        send_command(MODE_SEARCH, '0);
        send_command(MODE_POP,    32'sd77);
        send_command(MODE_POP,    '0);
        send_command(MODE_POP,    '0);
        send_command(MODE_POP,    '0);
        send_command(MODE_POP,    '0);
        drain_results();

        // long receiver stall while commands keep coming
        hold_off = 300;
        random_run(PHASE_ITEMS);
        drain_results();

        tx_idle_pct = 63;
        rx_idle_pct = 24;
        random_run(PHASE_ITEMS);
        drain_results();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_off    = 200;
        random_run(PHASE_ITEMS);
        drain_results();

        $display("summary: %0d commands, %0d results checked, %0d errors",
                 sb.commands, sb.results_seen, sb.errors);
        $display("summary: %0d done, %0d not found, %0d pops on empty, %0d inserts on full",
                 sb.status_seen[ST_DONE], sb.status_seen[ST_NOT_FOUND],
                 sb.status_seen[ST_EMPTY], sb.status_seen[ST_FULL]);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
